FILE: sv/hfcd_pkg.sv
// hfcd_pkg: shared constants of the hash framed command deframer
// no dependencies; imported by hash_framed_command_deframer_core, hfcd_frame_checker and testbench
package hfcd_pkg;

    // default ring size, overridable on the top level
    localparam int RING_DEPTH_DEFAULT = 16;

    // framing characters
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // offsets from the frame start
    localparam logic [3:0] OFS_DIGIT = 4'd1;
    localparam logic [3:0] OFS_CMD   = 4'd2;
    localparam logic [3:0] OFS_DATA  = 4'd3;

endpackage

FILE: sv/hfcd_ram.sv
// hfcd_ram: generic single write port, single read port ram
// registered read data; no dependencies
module hfcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/hash_framed_command_deframer_core.sv
// hash_framed_command_deframer_core: byte ring with '#' ... '\n' frame recognition
// depends on hfcd_pkg and hfcd_ram
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| command, data_count, data_byte, is_data, last
//
// an ordinary byte is only stored; the ring has a single read port, so a line feed after
// a pending '#' reads the digit of the remembered start, then searches backward, reading
// each slot and, for a slot holding '#', its digit, and goes back to idle if nothing is
// found; each result is read and loaded in turn, held off while out_ready stays low.
// reset is asynchronous and clears the per-entry valid bits at once, no sweep.
// bytes are taken only while the sequencer is idle; one finished result may wait
// in the output register while the next byte is taken.
module hash_framed_command_deframer_core #(
    parameter int RING_DEPTH = hfcd_pkg::RING_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [3:0] data_count,
    output logic [7:0] data_byte,
    output logic       is_data,
    output logic       last
);

    import hfcd_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_CHKD  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SHASH = 4'd4;
    localparam logic [3:0] S_SDIG  = 4'd5;
    localparam logic [3:0] S_CMD   = 4'd6;
    localparam logic [3:0] S_HDR   = 4'd7;
    localparam logic [3:0] S_DRD   = 4'd8;
    localparam logic [3:0] S_DLD   = 4'd9;

    // ring index plus a small offset, wrapped
    function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] i, input logic [3:0] k);
        logic [AW:0] sum;
        sum = {1'b0, i} + (AW+1)'(k);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // ring index minus one, wrapped
    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    logic [3:0]      st_reg, st_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]   start_reg, start_next;
    logic            sv_reg, sv_next;
    logic [AW-1:0]   lf_reg, lf_next;
    logic [AW-1:0]   scan_reg, scan_next;
    logic [AW-1:0]   h_reg, h_next;
    logic [3:0]      n_reg, n_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      command_reg, command_next;
    logic [3:0]      data_count_reg, data_count_next;
    logic [7:0]      data_byte_reg, data_byte_next;
    logic            is_data_reg, is_data_next;
    logic            last_reg, last_next;
    logic [RING_DEPTH-1:0] vld_reg, vld_next;
    logic            rd_vld_reg, rd_vld_next;

    logic            in_acc;
    logic            out_free;
    logic            ren;
    logic [AW-1:0]   raddr;
    logic [7:0]      ram_q;
    logic [7:0]      rd_data;
    logic            is_dig;
    logic [3:0]      dig_n;
    logic [AW-1:0]   chk_base;
    logic            end_ok;

    // ring storage
    hfcd_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (in_acc),
        .waddr (wp_reg),
        .wdata (rx_byte),
        .re    (ren),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // never-written slots read as zero
    assign rd_data = rd_vld_reg ? ram_q : 8'h00;

    // digit and frame length check on the read data
    assign is_dig   = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
    assign dig_n    = rd_data[3:0];
    assign chk_base = (st_reg == S_CHKD) ? start_reg : scan_reg;
    assign end_ok   = is_dig && (idx_add(chk_base, dig_n + OFS_DATA) == lf_reg);

    // handshakes
    assign in_ready = (st_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        st_next         = st_reg;
        wp_next         = wp_reg;
        start_next      = start_reg;
        sv_next         = sv_reg;
        lf_next         = lf_reg;
        scan_next       = scan_reg;
        h_next          = h_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        command_next    = command_reg;
        data_count_next = data_count_reg;
        data_byte_next  = data_byte_reg;
        is_data_next    = is_data_reg;
        last_next       = last_reg;
        vld_next        = vld_reg;
        ren             = 1'b0;
        raddr           = '0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    vld_next[wp_reg] = 1'b1;
                    wp_next          = idx_add(wp_reg, 4'd1);
                    lf_next          = wp_reg;
                    if ((rx_byte == CH_HASH) && !sv_reg)
                    begin
                        start_next = wp_reg;
                        sv_next    = 1'b1;
                    end
                    if ((rx_byte == CH_LF) && sv_reg)
                    begin
                        st_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                ren     = 1'b1;
                raddr   = idx_add(start_reg, OFS_DIGIT);
                st_next = S_CHKD;
            end
            S_CHKD:
            begin
                if (end_ok)
                begin
                    h_next  = start_reg;
                    n_next  = dig_n;
                    st_next = S_CMD;
                end
                else
                begin
                    scan_next = idx_dec(idx_dec(lf_reg));
                    st_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == start_reg)
                begin
                    st_next = S_IDLE;
                end
                else
                begin
                    ren     = 1'b1;
                    raddr   = scan_reg;
                    st_next = S_SHASH;
                end
            end
            S_SHASH:
            begin
                if (rd_data == CH_HASH)
                begin
                    ren     = 1'b1;
                    raddr   = idx_add(scan_reg, OFS_DIGIT);
                    st_next = S_SDIG;
                end
                else
                begin
                    scan_next = idx_dec(scan_reg);
                    st_next   = S_SCAN;
                end
            end
            S_SDIG:
            begin
                if (end_ok)
                begin
                    h_next  = scan_reg;
                    n_next  = dig_n;
                    st_next = S_CMD;
                end
                else
                begin
                    scan_next = idx_dec(scan_reg);
                    st_next   = S_SCAN;
                end
            end
            S_CMD:
            begin
                if (out_free)
                begin
                    ren     = 1'b1;
                    raddr   = idx_add(h_reg, OFS_CMD);
                    st_next = S_HDR;
                end
            end
            S_HDR:
            begin
                out_valid_next  = 1'b1;
                command_next    = rd_data;
                data_count_next = n_reg;
                data_byte_next  = 8'h00;
                is_data_next    = 1'b0;
                last_next       = (n_reg == 4'd0);
                sv_next         = 1'b0;
                cnt_next        = 4'd0;
                st_next         = (n_reg == 4'd0) ? S_IDLE : S_DRD;
            end
            S_DRD:
            begin
                if (out_free)
                begin
                    ren     = 1'b1;
                    raddr   = idx_add(h_reg, cnt_reg + OFS_DATA);
                    st_next = S_DLD;
                end
            end
            S_DLD:
            begin
                out_valid_next = 1'b1;
                data_byte_next = rd_data;
                is_data_next   = 1'b1;
                last_next      = (cnt_reg + 4'd1 == n_reg);
                cnt_next       = cnt_reg + 4'd1;
                st_next        = (cnt_reg + 4'd1 == n_reg) ? S_IDLE : S_DRD;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // valid bit of the slot being read
    assign rd_vld_next = ren ? vld_reg[raddr] : rd_vld_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            wp_reg        <= '0;
            start_reg     <= '0;
            sv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            wp_reg        <= wp_next;
            start_reg     <= start_next;
            sv_reg        <= sv_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        lf_reg         <= lf_next;
        scan_reg       <= scan_next;
        h_reg          <= h_next;
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        command_reg    <= command_next;
        data_count_reg <= data_count_next;
        data_byte_reg  <= data_byte_next;
        is_data_reg    <= is_data_next;
        last_reg       <= last_next;
    end

    // outputs
    assign out_valid  = out_valid_reg;
    assign command    = command_reg;
    assign data_count = data_count_reg;
    assign data_byte  = data_byte_reg;
    assign is_data    = is_data_reg;
    assign last       = last_reg;

    // a result is only loaded into an empty output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_HDR || st_reg == S_DLD) |-> !out_valid_reg)
        else $error("result loaded over an untaken result");

    // the pending marker is dropped only by a header load
    a_marker_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sv_reg) |-> $past(st_reg == S_HDR))
        else $error("marker cleared without a frame");

    // payload read stays inside the frame
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DRD || st_reg == S_DLD) |-> (cnt_reg < n_reg))
        else $error("payload counter past frame length");

    // the backward search never inspects the remembered start slot
    a_scan_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SHASH) |-> (scan_reg != start_reg))
        else $error("search ran onto the remembered start");

    // a frame is only worked on while a marker is pending
    a_frame_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CMD || st_reg == S_HDR) |-> sv_reg)
        else $error("frame output without a pending marker");

endmodule

FILE: verif/hfcd_frame_checker.sv
// hfcd_frame_checker: watches both channels of the frame deframer, predicts results, compares
// depends on hfcd_pkg for the framing characters and the frame offsets
module hfcd_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] command,
    input  logic [3:0] data_count,
    input  logic [7:0] data_byte,
    input  logic       is_data,
    input  logic       last,
    output int         mismatch_count,
    output int         expected_left
);

    import hfcd_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEFAULT;
    localparam int IW    = $clog2(DEPTH);

    typedef struct packed {
        logic [7:0] command;
        logic [3:0] data_count;
        logic [7:0] data_byte;
        logic       is_data;
        logic       last;
    } frame_result_t;

    // shadow copy of the byte ring and the start marker
    logic [7:0]    ring_copy [DEPTH];
    logic [IW-1:0] wr_pos;
    logic [IW-1:0] mark_pos;
    logic          mark_pending;

    frame_result_t frame_results [$];
    frame_result_t want;

    // digit, command and line feed line up for a frame starting at slot h
    function automatic logic frame_fits(input logic [IW-1:0] h, input logic [IW-1:0] lf_pos,
                                        output logic [3:0] n);
        logic [IW-1:0] idx;
        logic [7:0]    digit;
        idx   = h + OFS_DIGIT;
        digit = ring_copy[idx];
        n     = '0;
        if (digit < CH_ZERO || digit > CH_NINE)
            return 1'b0;
        n   = 4'(digit - CH_ZERO);
        idx = h + n + OFS_DATA;
        return (idx == lf_pos);
    endfunction

    // store one byte; on a line feed look for a frame and queue its results
    task automatic deframe_byte(input logic [7:0] b);
        logic [IW-1:0] lf_pos;
        logic [IW-1:0] scan;
        logic [IW-1:0] frame_start;
        logic [IW-1:0] idx;
        logic [3:0]    n;
        logic [7:0]    cmd;
        logic          found;
        frame_result_t r;
        if (b == CH_HASH && !mark_pending)
        begin
            mark_pos     = wr_pos;
            mark_pending = 1'b1;
        end
        ring_copy[wr_pos] = b;
        wr_pos = wr_pos + 1'b1;
        if (b != CH_LF || !mark_pending)
            return;

        lf_pos      = wr_pos - 1'b1;
        found       = 1'b0;
        frame_start = mark_pos;
        if (frame_fits(mark_pos, lf_pos, n))
        begin
            found = 1'b1;
        end
        else
        begin
            // backward search, stops on reaching the remembered start
            scan = wr_pos - 2'd3;
            while (!found && scan != mark_pos)
            begin
                if (ring_copy[scan] == CH_HASH && frame_fits(scan, lf_pos, n))
                begin
                    found       = 1'b1;
                    frame_start = scan;
                end
                else
                begin
                    scan = scan - 1'b1;
                end
            end
        end
        if (!found)
            return;

        mark_pending = 1'b0;
        idx = frame_start + OFS_CMD;
        cmd = ring_copy[idx];
        r.command    = cmd;
        r.data_count = n;
        r.data_byte  = '0;
        r.is_data    = 1'b0;
        r.last       = (n == 0);
        frame_results.push_back(r);
        for (int k = 0; k < n; k++)
        begin
            idx = frame_start + OFS_DATA + IW'(k);
            r.data_byte = ring_copy[idx];
            r.is_data   = 1'b1;
            r.last      = (k + 1 == n);
            frame_results.push_back(r);
        end
    endtask

    // predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (ring_copy[i])
                ring_copy[i] = '0;
            wr_pos         = '0;
            mark_pos       = '0;
            mark_pending   = 1'b0;
            frame_results.delete();
            mismatch_count = 0;
            expected_left  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (frame_results.size() == 0)
                begin
                    $display("%0t unexpected result: cmd=%h cnt=%0d data=%h is_data=%b last=%b",
                             $time, command, data_count, data_byte, is_data, last);
                    mismatch_count++;
                end
                else
                begin
                    want = frame_results.pop_front();
                    if (command !== want.command || data_count !== want.data_count ||
                        data_byte !== want.data_byte || is_data !== want.is_data ||
                        last !== want.last)
                    begin
                        $display("%0t mismatch: expected cmd=%h cnt=%0d data=%h is_data=%b last=%b",
                                 $time, want.command, want.data_count, want.data_byte,
                                 want.is_data, want.last);
                        $display("%0t           actual   cmd=%h cnt=%0d data=%h is_data=%b last=%b",
                                 $time, command, data_count, data_byte, is_data, last);
                        mismatch_count++;
                    end
                end
            end
            expected_left = frame_results.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// testbench: stimulus, receiver back-pressure, watchdog and verdict for the frame deframer
// depends on hfcd_pkg, hash_framed_command_deframer_core and hfcd_frame_checker
module testbench;

    import hfcd_pkg::*;

    localparam int ITEM_TOTAL    = 310;
    localparam int STALL_LIMIT   = 4000;
    localparam int LINGER_CYCLES = 120;
    localparam int HOLD_LEN      = 250;

    // directed opening: frame with nine data bytes, empty frame ending in slot zero, stale marker
    // with failed check, frame found by the backward search, line feed with no marker
    localparam logic [7:0] DIRECTED [26] = '{
        CH_HASH, 8'h39, 8'h00,
        8'hFF, 8'h00, 8'h23, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
        CH_LF,
        CH_HASH, CH_ZERO, 8'hFF, CH_LF,
        CH_HASH, 8'h35, CH_LF,
        CH_HASH, 8'h31, 8'h5A, 8'hC3, CH_LF,
        CH_LF
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] command;
    logic [3:0] data_count;
    logic [7:0] data_byte;
    logic       is_data;
    logic       last;

    int mismatch_count;
    int expected_left;

    // handshake and queue state as seen just before the next rising edge
    logic in_take   = 1'b0;
    logic out_take  = 1'b0;
    int   left_seen = 0;

    int send_idle_pct = 25;
    int recv_idle_pct = 88;
    int hold_cycles   = 0;
    int sent_count    = 0;
    int stall_count   = 0;

    hash_framed_command_deframer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .command    (command),
        .data_count (data_count),
        .data_byte  (data_byte),
        .is_data    (is_data),
        .last       (last)
    );

    hfcd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .command        (command),
        .data_count     (data_count),
        .data_byte      (data_byte),
        .is_data        (is_data),
        .last           (last),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        in_take   = in_valid && in_ready;
        out_take  = out_valid && out_ready;
        left_seen = expected_left;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (in_take || out_take)
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off counted down here
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // offer one byte, idling at random first, and wait for its transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_take)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering until every predicted result has been taken
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (left_seen != 0)
            @(posedge clk);
    endtask

    // random byte that is a '#' or line feed more often than chance
    function automatic logic [7:0] noise_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return CH_HASH;
        if (pick < 4)
            return CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_good_frame();
        logic [3:0] n;
        logic [7:0] b;
        n = 4'($urandom_range(0, 9));
        send_byte(CH_HASH);
        send_byte(CH_ZERO + n);
        send_byte(8'($urandom_range(0, 255)));
        for (int k = 0; k < n; k++)
        begin
            b = 8'($urandom_range(0, 255));
            // mostly keep line feeds out of the payload
            if (b == CH_LF && $urandom_range(0, 3) != 0)
                b = 8'h4C;
            send_byte(b);
        end
        send_byte(CH_LF);
    endtask

    // '#', a possibly wrong digit, then a payload of the wrong or right length
    task automatic send_broken_frame();
        int len;
        send_byte(CH_HASH);
        if ($urandom_range(0, 1) == 0)
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        else
            send_byte(8'($urandom_range(0, 255)));
        len = $urandom_range(0, 11);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_LF);
    endtask

    initial
    begin
        int phase;
        int pick;
        int burst;
        phase    = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);

        // random part: mostly well-formed frames, some noise and broken frames
        while (sent_count < ITEM_TOTAL)
        begin
            if (phase == 0 && sent_count >= 110)
            begin
                phase = 1;
                pause_until_drained();
                send_idle_pct = 88;
                recv_idle_pct = 25;
            end
            else if (phase == 1 && sent_count >= 210)
            begin
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_cycles   = HOLD_LEN;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_good_frame();
            end
            else if (pick < 82)
            begin
                burst = $urandom_range(1, 4);
                for (int k = 0; k < burst; k++)
                    send_byte(noise_byte());
            end
            else
            begin
                send_broken_frame();
            end
        end

        pause_until_drained();
        repeat (LINGER_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && left_seen == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/hfcd_pkg.sv
sv/hfcd_ram.sv
sv/hash_framed_command_deframer_core.sv
verif/hfcd_frame_checker.sv
verif/testbench.sv
